@@ src/mecf_pkg.sv @@
// Shared types, constants and helper functions of the MIDI event channel filter.
// Depends on nothing; used by midi_event_channel_filter.
`default_nettype none

package mecf_pkg;

   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [15:0] chan_mask_type;
   typedef logic [1:0]  msg_count_type;

   // Register index, taken from the word address of the configuration port.
   typedef enum logic [1:0] {
      REG_CHANNEL_MASK = 2'd0,
      REG_ANY_CHANNEL  = 2'd1,
      REG_ACCEPT_SYSEX = 2'd2
   } reg_index_type;

   // Message length in bytes, from the first byte of the message.
   function automatic msg_count_type msg_length(input logic [7:0] first_byte);
      msg_count_type len;
      len = 2'd1;
      if (first_byte >= 8'h80 && first_byte <= 8'hBF) begin
         len = 2'd3;
      end else if (first_byte >= 8'hC0 && first_byte <= 8'hDF) begin
         len = 2'd2;
      end else if (first_byte >= 8'hE0 && first_byte <= 8'hEF) begin
         len = 2'd3;
      end else if (first_byte == 8'hF1 || first_byte == 8'hF3) begin
         len = 2'd2;
      end else if (first_byte == 8'hF2) begin
         len = 2'd3;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

@@ src/midi_event_channel_filter.sv @@
// MIDI event channel filter: frames a raw MIDI byte stream and routes each message.
// Depends on mecf_pkg for constants, register indexes and the message length table.
`default_nettype none

// Each byte that enters on the req_ channel leaves on the rsp_ channel unchanged, tagged
// with the route of the message it belongs to (rsp_accepted high for the accept output).
// The route is decided on the first byte of each message. A status byte with the top bit
// set is accepted when its low nibble selects a set bit of the channel mask or when
// any_channel is set; 0xF0 opens a system exclusive message, running up to and including
// the next 0xF7, which is also accepted when accept_sysex is set. Bytes 0xF0 through 0xFF
// are tested against the mask by their low nibble like channel messages. A data byte at
// a message start is a rejected one-byte message, and status bytes other than 0xF7 inside
// an open message count as ordinary bytes of it. The block takes one byte per clock
// unless stalled: the framing state and the tagged byte are both registered at the edge
// that accepts the byte, so the item appears on the rsp_ side in the next cycle if the
// output register is free. A one-entry skid stage lets the input keep flowing when the
// output stalls; req_stall rises only when the skid stage is occupied. Configuration
// lies at byte addresses 0 (channel mask), 4 (any_channel) and 8 (accept_sysex), all
// reset to zero, and should be written only while no bytes are in flight.
module midi_event_channel_filter (
   input  wire                                 clock,
   input  wire                                 reset,
   // Input byte channel.
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [7:0]                          req_data_byte,
   // Result channel.
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_accepted,
   // Configuration port.
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [mecf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [mecf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mecf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import mecf_pkg::*;

   // Configuration registers.
   chan_mask_type chan_mask_ff;
   logic          any_channel_ff;
   logic          accept_sysex_ff;
   reg_index_type csr_index;
   logic          csr_write;

   // Framing state.
   msg_count_type bytes_left_ff, bytes_left_in;
   logic          in_sysex_ff, in_sysex_in;
   logic          route_ff, route_in;

   // Output register and skid stage.
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_acc_ff, out_acc_in;
   logic          skid_valid_ff, skid_valid_in;
   logic [7:0]    skid_byte_ff, skid_byte_in;
   logic          skid_acc_ff, skid_acc_in;

   logic          in_take;
   logic          out_take;
   logic          out_free;
   logic          msg_start;
   logic          new_route;

   // The configuration port answers at once; the register index is the word address.
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_CHANNEL_MASK: csr_prdata = {{(CSR_DATA_W-16){1'b0}}, chan_mask_ff};
         REG_ANY_CHANNEL:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, any_channel_ff};
         REG_ACCEPT_SYSEX: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, accept_sysex_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_mask_ff    <= '0;
         any_channel_ff  <= 1'b0;
         accept_sysex_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CHANNEL_MASK: chan_mask_ff    <= csr_pwdata[15:0];
            REG_ANY_CHANNEL:  any_channel_ff  <= csr_pwdata[0];
            REG_ACCEPT_SYSEX: accept_sysex_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Handshakes. The input stalls only when the skid stage already holds a byte.
   assign req_stall = skid_valid_ff;
   assign in_take   = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign out_free  = !out_valid_ff || out_take;

   // Message framing. A new message starts when nothing is open; its route is decided
   // from the first byte and held for the rest of the message.
   assign msg_start = !in_sysex_ff && (bytes_left_ff == 2'd0);

   always_comb begin
      new_route = 1'b0;
      if (req_data_byte[7] && (any_channel_ff || chan_mask_ff[req_data_byte[3:0]])) begin
         new_route = 1'b1;
      end
      if (req_data_byte == SYSEX_START && accept_sysex_ff) begin
         new_route = 1'b1;
      end
   end

   always_comb begin
      bytes_left_in = bytes_left_ff;
      in_sysex_in   = in_sysex_ff;
      route_in      = route_ff;
      if (in_take) begin
         if (msg_start) begin
            route_in = new_route;
            if (req_data_byte == SYSEX_START) begin
               in_sysex_in = 1'b1;
            end else begin
               // The first byte counts against the message length right away.
               bytes_left_in = msg_length(req_data_byte) - 2'd1;
            end
         end else if (in_sysex_ff) begin
            if (req_data_byte == SYSEX_END) begin
               in_sysex_in = 1'b0;
            end
         end else begin
            bytes_left_in = bytes_left_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         in_sysex_ff   <= 1'b0;
         route_ff      <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         in_sysex_ff   <= in_sysex_in;
         route_ff      <= route_in;
      end
   end

   // Output register with skid stage. When the output register frees up, a waiting
   // skid item moves forward first so order is kept.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_acc_in    = out_acc_ff;
      skid_valid_in = skid_valid_ff;
      skid_byte_in  = skid_byte_ff;
      skid_acc_in   = skid_acc_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_byte_in   = skid_byte_ff;
            out_acc_in    = skid_acc_ff;
            skid_valid_in = in_take;
            skid_byte_in  = req_data_byte;
            skid_acc_in   = route_in;
         end else begin
            out_valid_in  = in_take;
            out_byte_in   = req_data_byte;
            out_acc_in    = route_in;
         end
      end else if (in_take) begin
         skid_valid_in = 1'b1;
         skid_byte_in  = req_data_byte;
         skid_acc_in   = route_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_acc_ff   <= out_acc_in;
      skid_byte_ff <= skid_byte_in;
      skid_acc_ff  <= skid_acc_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_accepted = out_acc_ff;

endmodule

`default_nettype wire
